/* rtl/spq_pkg.sv */
// Shared types and constants for the sorted priority queue.
// No dependencies; used by spq_cell and sorted_priority_queue_unit.
package spq_pkg;

  // Number of cells in the sorted chain.
  localparam int CAPACITY = 64;
  // Width of the fill count, which must hold CAPACITY itself.
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Operation codes carried by the cmd field.
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // Status codes reported with every result.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;

  // One stored pair.
  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] prio;
  } entry_t;

  // Control broadcast from the top level to every cell.
  typedef struct packed {
    logic             ins_en;
    logic             rem_en;
    logic [CNT_W-1:0] count;
    entry_t           item;
  } ctrl_t;

endpackage

/* rtl/sorted_priority_queue_unit.sv */
// A result beat is registered and appears in the cycle after its input beat is accepted.
// One operation per cycle is taken while the result side does not stall;
// the broadcast compare across the cell chain updates all cells together.
// Reset clears the fill count and the result valid; cell contents are left
// as they are and are never read until written.
// Top level of the sorted priority queue; depends on spq_pkg and spq_cell.
module sorted_priority_queue_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_cmd,
  input  logic signed [31:0] in_item_value,
  input  logic signed [31:0] in_item_priority,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_removed_value,
  output logic signed [31:0] out_removed_priority,
  output logic signed [31:0] out_top_value,
  output logic signed [31:0] out_top_priority,
  output logic               out_is_empty,
  output logic               out_is_full,
  output logic [1:0]         out_status
);

  localparam int CAP = spq_pkg::CAPACITY;
  localparam int CW  = spq_pkg::CNT_W;

  logic [CW-1:0]   count_r, count_nxt;
  logic            out_valid_r, out_valid_nxt;
  spq_pkg::entry_t removed_r, removed_nxt;
  spq_pkg::entry_t top_r, top_nxt;
  logic            empty_r, empty_nxt;
  logic            full_r, full_nxt;
  logic [1:0]      status_r, status_nxt;

  logic            accept;
  logic            is_full_now;
  logic            is_empty_now;
  logic            ins_ok;
  logic            rem_ok;
  spq_pkg::ctrl_t  ctrl;
  spq_pkg::entry_t cell_entry [CAP];
  logic            cell_keep  [CAP];

  // Input handshake: a new beat is taken unless a held result is stalled.
  assign in_stall     = out_valid_r && out_stall;
  assign accept       = in_valid && !in_stall;
  assign is_full_now  = count_r == CW'(CAP);
  assign is_empty_now = count_r == '0;
  assign ins_ok = accept && (in_cmd == spq_pkg::CMD_INSERT) && !is_full_now;
  assign rem_ok = accept && (in_cmd == spq_pkg::CMD_REMOVE) && !is_empty_now;

  // Control broadcast to the chain.
  always_comb begin
    ctrl.ins_en         = ins_ok;
    ctrl.rem_en         = rem_ok;
    ctrl.count          = count_r;
    ctrl.item.value     = in_item_value;
    ctrl.item.prio      = in_item_priority;
  end

  // The chain of cells; the head is cell zero.
  for (genvar i = 0; i < CAP; i++) begin : g_cell
    spq_pkg::entry_t prev_e;
    spq_pkg::entry_t next_e;
    logic            prev_k;
    if (i == 0) begin : g_first
      assign prev_e = ctrl.item;
      assign prev_k = 1'b1;
    end else begin : g_mid
      assign prev_e = cell_entry[i-1];
      assign prev_k = cell_keep[i-1];
    end
    if (i == CAP - 1) begin : g_last
      assign next_e = '0;
    end else begin : g_inner
      assign next_e = cell_entry[i+1];
    end
    spq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .cell_idx  (CW'(i)),
      .prev_entry(prev_e),
      .prev_keep (prev_k),
      .next_entry(next_e),
      .entry     (cell_entry[i]),
      .keep      (cell_keep[i])
    );
  end

  // Fill count and result beat for the accepted operation.
  always_comb begin
    count_nxt   = count_r;
    removed_nxt = removed_r;
    top_nxt     = top_r;
    empty_nxt   = empty_r;
    full_nxt    = full_r;
    status_nxt  = status_r;
    if (accept) begin
      removed_nxt = '0;
      status_nxt  = spq_pkg::ST_OK;
      if (ins_ok) begin
        count_nxt = count_r + CW'(1);
        top_nxt   = cell_keep[0] ? cell_entry[0] : ctrl.item;
      end else if (rem_ok) begin
        count_nxt   = count_r - CW'(1);
        removed_nxt = cell_entry[0];
        top_nxt     = (count_r > CW'(1)) ? cell_entry[1] : '0;
      end else begin
        status_nxt = (in_cmd == spq_pkg::CMD_INSERT) ? spq_pkg::ST_OVERFLOW
                                                     : spq_pkg::ST_UNDERFLOW;
        top_nxt    = is_empty_now ? '0 : cell_entry[0];
      end
      empty_nxt = count_nxt == '0;
      full_nxt  = count_nxt == CW'(CAP);
    end
  end

  // Output valid: set by an accepted beat, cleared once the result is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    removed_r <= removed_nxt;
    top_r     <= top_nxt;
    empty_r   <= empty_nxt;
    full_r    <= full_nxt;
    status_r  <= status_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_removed_value    = removed_r.value;
  assign out_removed_priority = removed_r.prio;
  assign out_top_value        = top_r.value;
  assign out_top_priority     = top_r.prio;
  assign out_is_empty         = empty_r;
  assign out_is_full          = full_r;
  assign out_status           = status_r;

  // The fill count never exceeds the number of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAP))
    else $error("fill count above capacity");

  // An insert into a full queue reports overflow and leaves it full.
  a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_cmd == spq_pkg::CMD_INSERT && is_full_now) |=>
      (out_status == spq_pkg::ST_OVERFLOW && out_is_full && count_r == CW'(CAP)))
    else $error("overflow not reported");

  // A remove from an empty queue reports underflow with zeroed fields.
  a_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_cmd == spq_pkg::CMD_REMOVE && is_empty_now) |=>
      (out_status == spq_pkg::ST_UNDERFLOW && out_is_empty &&
       out_removed_value == '0 && out_top_priority == '0))
    else $error("underflow not reported");

  // The result flags agree with the fill count after every accepted beat.
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (out_is_empty == (count_r == '0)) && (out_is_full == (count_r == CW'(CAP))))
    else $error("result flags disagree with fill count");

endmodule

/* rtl/spq_cell.sv */
// One cell of the sorted chain: holds a single pair and its compare.
// Depends on spq_pkg for the entry and control types.
module spq_cell (
  input  logic                     clk,
  input  spq_pkg::ctrl_t           ctrl,
  input  logic [spq_pkg::CNT_W-1:0] cell_idx,
  input  spq_pkg::entry_t          prev_entry,
  input  logic                     prev_keep,
  input  spq_pkg::entry_t          next_entry,
  output spq_pkg::entry_t          entry,
  output logic                     keep
);

  spq_pkg::entry_t entry_r;
  logic            occupied;

  // A cell keeps its pair on insert when it holds an entry of strictly
  // higher priority than the incoming one.
  assign occupied = cell_idx < ctrl.count;
  assign keep     = occupied && ($signed(entry_r.prio) > $signed(ctrl.item.prio));
  assign entry    = entry_r;

  // Insert: the first non-keeping cell takes the new pair, the cells below
  // it shift down. Remove: every cell takes its lower neighbor.
  always_ff @(posedge clk) begin
    if (ctrl.ins_en) begin
      if (!keep) begin
        entry_r <= prev_keep ? ctrl.item : prev_entry;
      end
    end else if (ctrl.rem_en) begin
      entry_r <= next_entry;
    end
  end

endmodule

/* tb/spq_checker.sv */
// Checker for sorted_priority_queue_unit: watches the operation and result channels,
// predicts every result beat with its own sorted-queue model and compares field by field.
// Depends on spq_pkg for the capacity, the operation codes and the status codes.
module spq_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_cmd,
  input  logic signed [31:0] in_item_value,
  input  logic signed [31:0] in_item_priority,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_removed_value,
  input  logic signed [31:0] out_removed_priority,
  input  logic signed [31:0] out_top_value,
  input  logic signed [31:0] out_top_priority,
  input  logic               out_is_empty,
  input  logic               out_is_full,
  input  logic [1:0]         out_status,
  output int                 error_count,
  output int                 pending_count
);

  // One predicted result beat.
  typedef struct {
    logic signed [31:0] removed_value;
    logic signed [31:0] removed_prio;
    logic signed [31:0] head_value;
    logic signed [31:0] head_prio;
    logic               empty;
    logic               full;
    logic [1:0]         status;
  } queue_result_t;

  // Model of the queue contents, kept in descending priority order.
  logic signed [31:0] slot_val  [spq_pkg::CAPACITY];
  logic signed [31:0] slot_prio [spq_pkg::CAPACITY];
  int                 slot_fill;

  queue_result_t expected_results[$];
  queue_result_t want;

  // Apply one accepted operation to the model and queue the result it produces.
  task automatic apply_queue_op(input logic cmd, input logic signed [31:0] val,
                                input logic signed [31:0] prio);
    queue_result_t r;
    int            pos;
    int            i;
    r.removed_value = '0;
    r.removed_prio  = '0;
    r.status        = spq_pkg::ST_OK;
    if (cmd == spq_pkg::CMD_INSERT) begin
      if (slot_fill >= spq_pkg::CAPACITY) begin
        r.status = spq_pkg::ST_OVERFLOW;
      end else begin
        // The new pair lands after every strictly higher priority, ahead of ties.
        pos = 0;
        while (pos < slot_fill && slot_prio[pos] > prio) pos++;
        for (i = slot_fill; i > pos; i--) begin
          slot_val[i]  = slot_val[i-1];
          slot_prio[i] = slot_prio[i-1];
        end
        slot_val[pos]  = val;
        slot_prio[pos] = prio;
        slot_fill++;
      end
    end else begin
      if (slot_fill == 0) begin
        r.status = spq_pkg::ST_UNDERFLOW;
      end else begin
        r.removed_value = slot_val[0];
        r.removed_prio  = slot_prio[0];
        for (i = 1; i < slot_fill; i++) begin
          slot_val[i-1]  = slot_val[i];
          slot_prio[i-1] = slot_prio[i];
        end
        slot_fill--;
      end
    end
    r.head_value = (slot_fill != 0) ? slot_val[0] : '0;
    r.head_prio  = (slot_fill != 0) ? slot_prio[0] : '0;
    r.empty      = (slot_fill == 0);
    r.full       = (slot_fill >= spq_pkg::CAPACITY);
    expected_results.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      error_count++;
      $display("%0t: %s expected %h actual %h", $time, name, exp_val, act_val);
    end
  endtask

  // Result beats are checked before the operation beat of the same edge is modeled;
  // a result never appears in the cycle its operation is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      slot_fill = 0;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          error_count++;
          $display("%0t: result beat expected none actual status %h top %h",
                   $time, out_status, out_top_value);
        end else begin
          want = expected_results.pop_front();
          check_field("removed_value", want.removed_value, out_removed_value);
          check_field("removed_priority", want.removed_prio, out_removed_priority);
          check_field("top_value", want.head_value, out_top_value);
          check_field("top_priority", want.head_prio, out_top_priority);
          check_field("is_empty", 32'(want.empty), 32'(out_is_empty));
          check_field("is_full", 32'(want.full), 32'(out_is_full));
          check_field("status", 32'(want.status), 32'(out_status));
        end
      end
      if (in_valid && !in_stall) begin
        apply_queue_op(in_cmd, in_item_value, in_item_priority);
      end
    end
    pending_count = expected_results.size();
  end

endmodule

/* tb/tb_top.sv */
// Testbench top for sorted_priority_queue_unit: drives directed and random queue
// operations with random idling and gives the verdict. Depends on spq_pkg and spq_checker.
module tb_top;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_cmd;
  logic signed [31:0] in_item_value;
  logic signed [31:0] in_item_priority;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_removed_value;
  logic signed [31:0] out_removed_priority;
  logic signed [31:0] out_top_value;
  logic signed [31:0] out_top_priority;
  logic               out_is_empty;
  logic               out_is_full;
  logic [1:0]         out_status;

  int error_count;
  int pending_count;
  int send_gap_pct;
  int recv_stall_pct;
  bit hold_request;
  bit hold_seen;
  int hold_left;

  sorted_priority_queue_unit u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_cmd               (in_cmd),
    .in_item_value        (in_item_value),
    .in_item_priority     (in_item_priority),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_removed_value    (out_removed_value),
    .out_removed_priority (out_removed_priority),
    .out_top_value        (out_top_value),
    .out_top_priority     (out_top_priority),
    .out_is_empty         (out_is_empty),
    .out_is_full          (out_is_full),
    .out_status           (out_status)
  );

  spq_checker u_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_cmd               (in_cmd),
    .in_item_value        (in_item_value),
    .in_item_priority     (in_item_priority),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_removed_value    (out_removed_value),
    .out_removed_priority (out_removed_priority),
    .out_top_value        (out_top_value),
    .out_top_priority     (out_top_priority),
    .out_is_empty         (out_is_empty),
    .out_is_full          (out_is_full),
    .out_status           (out_status),
    .error_count          (error_count),
    .pending_count        (pending_count)
  );

  always #1 clk = ~clk;

  // Run limit, far above the slowest correct run.
  initial begin
    #1000000;
    $display("sorted_priority_queue_unit: mismatch");
    $finish;
  end

  // Result side: a requested long hold-off is counted here, otherwise random stalls.
  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    hold_seen = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_seen) begin
        hold_seen = 1'b1;
        hold_left = 160;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Offer one operation beat, after a random gap; called and returns at a falling edge.
  task automatic offer_op(input logic cmd, input logic [31:0] val, input logic [31:0] prio);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_cmd           <= cmd;
    in_item_value    <= val;
    in_item_priority <= prio;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Stop offering and wait until every predicted result beat has arrived.
  task automatic drain_results();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pending_count != 0 && guard < 50000) begin
      @(negedge clk);
      guard++;
    end
  endtask

  // Priorities cluster often, so ties and ordering among equals get exercised.
  function automatic logic [31:0] pick_prio();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(6) - 3;
      2: return $urandom_range(1) ? 32'h7fff_ffff - $urandom_range(1)
                                  : 32'h8000_0000 + $urandom_range(1);
      default: return $urandom_range(15) << 20;
    endcase
  endfunction

  // Random traffic in bursts that lean toward filling, draining or holding the level.
  task automatic run_traffic(input int count);
    int left;
    int burst;
    int insert_pct;
    left = count;
    while (left > 0) begin
      case ($urandom_range(2))
        0: insert_pct = 90;
        1: insert_pct = 10;
        default: insert_pct = 50;
      endcase
      burst = $urandom_range(120, 40);
      if (burst > left) burst = left;
      repeat (burst) begin
        offer_op(($urandom_range(99) < insert_pct) ? spq_pkg::CMD_INSERT
                                                   : spq_pkg::CMD_REMOVE,
                 $urandom, pick_prio());
      end
      left -= burst;
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_cmd           = spq_pkg::CMD_INSERT;
    in_item_value    = '0;
    in_item_priority = '0;
    hold_request     = 1'b0;
    send_gap_pct     = 23;
    recv_stall_pct   = 63;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: underflow on empty, field extremes, ties served newest first.
    offer_op(spq_pkg::CMD_REMOVE, 32'h1234_5678, 32'h0000_0001);
    offer_op(spq_pkg::CMD_INSERT, 32'h7fff_ffff, 32'h7fff_ffff);
    offer_op(spq_pkg::CMD_INSERT, 32'h8000_0000, 32'h8000_0000);
    offer_op(spq_pkg::CMD_INSERT, 32'h0000_0000, 32'h0000_0000);
    offer_op(spq_pkg::CMD_INSERT, 32'hffff_ffff, 32'hffff_ffff);
    offer_op(spq_pkg::CMD_INSERT, 32'd11, 32'd5);
    offer_op(spq_pkg::CMD_INSERT, 32'd22, 32'd5);
    offer_op(spq_pkg::CMD_INSERT, 32'd33, 32'd5);
    repeat (7) offer_op(spq_pkg::CMD_REMOVE, $urandom, $urandom);
    offer_op(spq_pkg::CMD_REMOVE, 32'hffff_ffff, 32'hffff_ffff);
    offer_op(spq_pkg::CMD_INSERT, 32'hffff_fffb, 32'h8000_0000);
    offer_op(spq_pkg::CMD_INSERT, 32'd6, 32'h8000_0000);
    offer_op(spq_pkg::CMD_REMOVE, 32'd0, 32'd0);
    offer_op(spq_pkg::CMD_REMOVE, 32'd0, 32'd0);

    // Hold the result side off so that the block stalls its input, and keep offering
    // inserts: the queue fills and overflows. Then drain it past empty.
    hold_request = 1'b1;
    repeat (70) offer_op(spq_pkg::CMD_INSERT, $urandom, pick_prio());
    drain_results();
    repeat (66) offer_op(spq_pkg::CMD_REMOVE, $urandom, $urandom);

    run_traffic(400);

    send_gap_pct   = 63;
    recv_stall_pct = 23;
    run_traffic(400);

    send_gap_pct   = 0;
    recv_stall_pct = 0;
    run_traffic(400);

    drain_results();
    repeat (8) @(negedge clk);
    if (error_count == 0 && pending_count == 0) begin
      $display("sorted_priority_queue_unit: match");
    end else begin
      $display("sorted_priority_queue_unit: mismatch");
    end
    $finish;
  end

endmodule

/* sorted_priority_queue_unit.f */
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_unit.sv
tb/spq_checker.sv
tb/tb_top.sv
